// ===== rtl/core/nfba_pkg.sv =====
// Shared constants and codes for the next-fit bitmap allocator.
package nfba_pkg;

    localparam int DEF_MAX_ENTRIES = 65536;
    localparam int DEF_WORD_BITS   = 64;

    localparam int POS_W    = 32;
    localparam int CNT_W    = 17;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 32;

    localparam logic [CMD_W-1:0] CMD_MARK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_CHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b1;

endpackage

// ===== rtl/core/nfba_map_ram.sv =====
// Allocation bitmap storage: one write port, one registered read port.
module nfba_map_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int WORD_W = 64
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/nfba_word_scan.sv =====
// Finds the lowest clear bit of one bitmap word inside an index window [lo, hi).
module nfba_word_scan #(
    parameter int WORD_W = 64,
    parameter int BIT_W  = 6,
    parameter int ADDR_W = 10,
    parameter int G_W    = 18
) (
    input  logic [WORD_W-1:0] data,
    input  logic [ADDR_W-1:0] addr,
    input  logic [G_W-1:0]    lo,
    input  logic [G_W-1:0]    hi,
    output logic              found,
    output logic [BIT_W-1:0]  bit_idx
);

    localparam int WA_W = G_W - BIT_W;

    logic [WA_W-1:0]   addr_x;
    logic [WA_W-1:0]   lo_w;
    logic [WA_W-1:0]   hi_w;
    logic [BIT_W-1:0]  lo_b;
    logic [BIT_W-1:0]  hi_b;
    logic [WORD_W-1:0] ge_mask;
    logic [WORD_W-1:0] lt_mask;
    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] low;

    assign addr_x = WA_W'(addr);
    assign lo_w   = lo[G_W-1:BIT_W];
    assign hi_w   = hi[G_W-1:BIT_W];
    assign lo_b   = lo[BIT_W-1:0];
    assign hi_b   = hi[BIT_W-1:0];

    always_comb
    begin
        ge_mask = '0;
        lt_mask = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (addr_x > lo_w || (addr_x == lo_w && BIT_W'(j) >= lo_b))
            begin
                ge_mask[j] = 1'b1;
            end
            if (addr_x < hi_w || (addr_x == hi_w && BIT_W'(j) < hi_b))
            begin
                lt_mask[j] = 1'b1;
            end
        end
    end

    // isolate the lowest free candidate, then encode its position
    assign cand = ~data & ge_mask & lt_mask;
    assign low  = cand & (~cand + WORD_W'(1));

    always_comb
    begin
        bit_idx = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (low[j])
            begin
                bit_idx = bit_idx | BIT_W'(j);
            end
        end
    end

    assign found = |cand;

endmodule

// ===== rtl/core/next_fit_bitmap_allocator_unit.sv =====
// Top level of the next-fit bitmap allocator: control, counters and result register.
//
// Requests arrive on in_valid/in_ready with command and position; each request
// yields exactly one result on out_valid/out_ready (status, result_position,
// free_count). Configuration is written through cfg_write/cfg_index/cfg_data,
// by the user only while no request is in flight; the block does not enforce it.
// One request is worked at a time. Mark and release are one read-modify-write
// of the bitmap memory: the word is read in decode, written back in the
// read-modify-write state, and the result is registered in finish. Requests
// refused at decode (out of range, none free, unused command) go straight to
// finish. Allocate reads one bitmap word per cycle from the word holding the
// entry after the last allocation, wrapping round, and checks 1 to DEPTH + 1
// words (DEPTH = MAX_ENTRIES / WORD_BITS rounded up); a grant writes the word
// back before finish. The search is bound by the single bitmap read port.
// After reset the block sweeps the bitmap to zero, one word per cycle, over all
// DEPTH words (1024 at the defaults), with in_ready low; config writes are taken.
// A finished result waits in the output register; the next request is still
// accepted, and its result is held back only until that register is taken.
module next_fit_bitmap_allocator_unit
    import nfba_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int WORD_BITS   = DEF_WORD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     command,
    input  logic [POS_W-1:0]     position,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [POS_W-1:0]     result_position,
    output logic [CNT_W-1:0]     free_count,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int WB     = 1 << BIT_W;
    localparam int DEPTH  = (MAX_ENTRIES + WB - 1) / WB;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int N_W    = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int G_W    = ((N_W > BIT_W) ? N_W : BIT_W) + 1;
    localparam int WA_W   = G_W - BIT_W;
    localparam int EC_W   = (N_W > CNT_W) ? N_W : CNT_W;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DECODE   = 3'd2;
    localparam logic [2:0] S_RMW      = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_ALLOC_WR = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clear_addr_reg, clear_addr_next;
    logic [POS_W-1:0]    base_offset_reg;
    logic [CNT_W-1:0]    entry_count_reg;
    logic [CMD_W-1:0]    req_cmd_reg, req_cmd_next;
    logic [POS_W-1:0]    req_pos_reg, req_pos_next;
    logic [G_W-1:0]      req_idx_reg, req_idx_next;
    logic [N_W-1:0]      used_count_reg, used_count_next;
    logic [IDX_W-1:0]    last_alloc_reg, last_alloc_next;
    logic [G_W-1:0]      s_reg, s_next;
    logic [ADDR_W-1:0]   issue_addr_reg, issue_addr_next;
    logic                issue_pass_reg, issue_pass_next;
    logic                issue_on_reg, issue_on_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic                rd_pass_reg, rd_pass_next;
    logic                rd_last_reg, rd_last_next;
    logic [G_W-1:0]      found_idx_reg, found_idx_next;
    logic [WB-1:0]       found_word_reg, found_word_next;
    logic [BIT_W-1:0]    found_bit_reg, found_bit_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]    out_free_reg, out_free_next;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [WB-1:0]       ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [WB-1:0]       ram_rd_data;

    logic [EC_W-1:0]     ec_x;
    logic [N_W-1:0]      live_n;
    logic [G_W-1:0]      n_g;
    logic [G_W-1:0]      nm1_g;
    logic [WA_W-1:0]     nm1_word;
    logic [POS_W-1:0]    dec_diff;
    logic [G_W-1:0]      dec_idx;
    logic [WA_W-1:0]     dec_word;
    logic [WA_W-1:0]     req_word;
    logic [G_W-1:0]      last_g;
    logic [G_W-1:0]      s_first;
    logic [G_W-1:0]      s_comb;
    logic [WA_W-1:0]     s_comb_word;
    logic [WA_W-1:0]     s_word;
    logic [WA_W-1:0]     found_word_addr;
    logic [ADDR_W-1:0]   pass_end;
    logic [G_W-1:0]      scan_lo;
    logic [G_W-1:0]      scan_hi;
    logic                scan_found;
    logic [BIT_W-1:0]    scan_bit;
    logic [N_W-1:0]      free_left;
    logic [N_W-1:0]      used_inc;
    logic [N_W-1:0]      used_dec;
    logic                in_accept;

    nfba_map_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .WORD_W (WB)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign scan_lo = rd_pass_reg ? '0 : s_reg;
    assign scan_hi = rd_pass_reg ? s_reg : n_g;

    nfba_word_scan #(
        .WORD_W (WB),
        .BIT_W  (BIT_W),
        .ADDR_W (ADDR_W),
        .G_W    (G_W)
    ) u_scan (
        .data    (ram_rd_data),
        .addr    (rd_addr_reg),
        .lo      (scan_lo),
        .hi      (scan_hi),
        .found   (scan_found),
        .bit_idx (scan_bit)
    );

    // live entry count, clamped to 1..MAX_ENTRIES
    assign ec_x   = EC_W'(entry_count_reg);
    assign live_n = (ec_x == '0) ? N_W'(1) :
                    (ec_x > EC_W'(MAX_ENTRIES)) ? N_W'(MAX_ENTRIES) : N_W'(ec_x);
    assign n_g      = G_W'(live_n);
    assign nm1_g    = n_g - G_W'(1);
    assign nm1_word = nm1_g[G_W-1:BIT_W];

    assign dec_diff = req_pos_reg - base_offset_reg;
    assign dec_idx  = G_W'(dec_diff);
    assign dec_word = dec_idx[G_W-1:BIT_W];
    assign req_word = req_idx_reg[G_W-1:BIT_W];

    // next-fit start point
    assign last_g      = G_W'(last_alloc_reg);
    assign s_first     = (last_g < nm1_g) ? last_g + G_W'(1) : G_W'(1);
    assign s_comb      = (s_first >= n_g) ? '0 : s_first;
    assign s_comb_word = s_comb[G_W-1:BIT_W];
    assign s_word      = s_reg[G_W-1:BIT_W];
    assign found_word_addr = found_idx_reg[G_W-1:BIT_W];

    assign pass_end = issue_pass_reg ? s_word[ADDR_W-1:0] : nm1_word[ADDR_W-1:0];

    assign free_left = (used_count_reg < live_n) ? live_n - used_count_reg : '0;
    assign used_inc  = (used_count_reg < N_W'(MAX_ENTRIES)) ? used_count_reg + N_W'(1)
                                                             : used_count_reg;
    assign used_dec  = (used_count_reg != '0) ? used_count_reg - N_W'(1) : used_count_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        req_cmd_next    = req_cmd_reg;
        req_pos_next    = req_pos_reg;
        req_idx_next    = req_idx_reg;
        used_count_next = used_count_reg;
        last_alloc_next = last_alloc_reg;
        s_next          = s_reg;
        issue_addr_next = issue_addr_reg;
        issue_pass_next = issue_pass_reg;
        issue_on_next   = issue_on_reg;
        rd_vld_next     = 1'b0;
        rd_addr_next    = rd_addr_reg;
        rd_pass_next    = rd_pass_reg;
        rd_last_next    = rd_last_reg;
        found_idx_next  = found_idx_reg;
        found_word_next = found_word_reg;
        found_bit_next  = found_bit_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_free_next   = out_free_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en       = 1'b1;
                ram_wr_addr     = clear_addr_reg;
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
                if (clear_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_cmd_next = command;
                    req_pos_next = position;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_pos_next = '0;
                case (req_cmd_reg)
                    CMD_MARK, CMD_RELEASE:
                    begin
                        if (dec_diff >= POS_W'(live_n))
                        begin
                            res_status_next = STAT_RANGE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            req_idx_next = dec_idx;
                            ram_rd_en    = 1'b1;
                            ram_rd_addr  = dec_word[ADDR_W-1:0];
                            state_next   = S_RMW;
                        end
                    end
                    CMD_ALLOC:
                    begin
                        if (used_count_reg >= live_n)
                        begin
                            res_status_next = STAT_NONE_FREE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            s_next          = s_comb;
                            issue_addr_next = s_comb_word[ADDR_W-1:0];
                            issue_pass_next = 1'b0;
                            issue_on_next   = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_NO_CHANGE;
                        state_next      = S_FINISH;
                    end
                endcase
            end

            S_RMW:
            begin
                ram_wr_addr     = req_word[ADDR_W-1:0];
                res_status_next = STAT_NO_CHANGE;
                if (req_cmd_reg == CMD_MARK)
                begin
                    if (!ram_rd_data[req_idx_reg[BIT_W-1:0]])
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_data     = ram_rd_data | (WB'(1) << req_idx_reg[BIT_W-1:0]);
                        used_count_next = used_inc;
                        res_status_next = STAT_DONE;
                    end
                end
                else
                begin
                    if (ram_rd_data[req_idx_reg[BIT_W-1:0]])
                    begin
                        ram_wr_en       = 1'b1;
                        ram_wr_data     = ram_rd_data & ~(WB'(1) << req_idx_reg[BIT_W-1:0]);
                        used_count_next = used_dec;
                        res_status_next = STAT_DONE;
                    end
                end
                state_next = S_FINISH;
            end

            S_SCAN:
            begin
                if (issue_on_reg)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = issue_addr_reg;
                    rd_vld_next  = 1'b1;
                    rd_addr_next = issue_addr_reg;
                    rd_pass_next = issue_pass_reg;
                    rd_last_next = issue_pass_reg && (issue_addr_reg == pass_end);
                    if (issue_addr_reg == pass_end)
                    begin
                        if (issue_pass_reg)
                        begin
                            issue_on_next = 1'b0;
                        end
                        else
                        begin
                            issue_pass_next = 1'b1;
                            issue_addr_next = '0;
                        end
                    end
                    else
                    begin
                        issue_addr_next = issue_addr_reg + ADDR_W'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    if (scan_found)
                    begin
                        found_word_next = ram_rd_data;
                        found_bit_next  = scan_bit;
                        found_idx_next  = G_W'({rd_addr_reg, scan_bit});
                        issue_on_next   = 1'b0;
                        rd_vld_next     = 1'b0;
                        state_next      = S_ALLOC_WR;
                    end
                    else if (rd_last_reg)
                    begin
                        res_status_next = STAT_NONE_FREE;
                        issue_on_next   = 1'b0;
                        rd_vld_next     = 1'b0;
                        state_next      = S_FINISH;
                    end
                end
            end

            S_ALLOC_WR:
            begin
                ram_wr_en       = 1'b1;
                ram_wr_addr     = found_word_addr[ADDR_W-1:0];
                ram_wr_data     = found_word_reg | (WB'(1) << found_bit_reg);
                used_count_next = used_inc;
                last_alloc_next = IDX_W'(found_idx_reg);
                res_pos_next    = POS_W'(found_idx_reg) + base_offset_reg;
                res_status_next = STAT_DONE;
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_free_next   = CNT_W'(free_left);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clear_addr_reg  <= '0;
            base_offset_reg <= '0;
            entry_count_reg <= CNT_W'(65536);
            used_count_reg  <= '0;
            last_alloc_reg  <= '0;
            issue_on_reg    <= 1'b0;
            rd_vld_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            used_count_reg <= used_count_next;
            last_alloc_reg <= last_alloc_next;
            issue_on_reg   <= issue_on_next;
            rd_vld_reg     <= rd_vld_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write && cfg_index == REG_BASE_OFFSET)
            begin
                base_offset_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_ENTRY_COUNT)
            begin
                entry_count_reg <= cfg_data[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_cmd_reg     <= req_cmd_next;
        req_pos_reg     <= req_pos_next;
        req_idx_reg     <= req_idx_next;
        s_reg           <= s_next;
        issue_addr_reg  <= issue_addr_next;
        issue_pass_reg  <= issue_pass_next;
        rd_addr_reg     <= rd_addr_next;
        rd_pass_reg     <= rd_pass_next;
        rd_last_reg     <= rd_last_next;
        found_idx_reg   <= found_idx_next;
        found_word_reg  <= found_word_next;
        found_bit_reg   <= found_bit_next;
        res_status_reg  <= res_status_next;
        res_pos_reg     <= res_pos_next;
        out_status_reg  <= out_status_next;
        out_pos_reg     <= out_pos_next;
        out_free_reg    <= out_free_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign result_position = out_pos_reg;
    assign free_count      = out_free_reg;

`ifndef ASSERT_OFF
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= N_W'(MAX_ENTRIES))
        else $error("used count above capacity");

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("bitmap read and write in one cycle");

    a_alloc_bit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_WR) |-> !found_word_reg[found_bit_reg])
        else $error("allocate picked a used entry");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");
`endif

endmodule

// ===== test/next_fit_bitmap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the next-fit bitmap allocator: directed script, then random phases.
module next_fit_bitmap_allocator_unit_tb;
    import nfba_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CALM_LO = 500;
    localparam int CALM_HI = 650;
    localparam int N_PHASES = 7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    result_position;
        logic [CNT_W-1:0]    free_count;
    } alloc_result_t;

    typedef struct packed {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [CFG_W-1:0]     reg_value;
        logic [CMD_W-1:0]     cmd;
        logic [POS_W-1:0]     pos;
        bit                   typed;
        alloc_result_t        want;
    } script_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     command = CMD_MARK;
    logic [POS_W-1:0]     position = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     result_position;
    logic [CNT_W-1:0]     free_count;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_BASE_OFFSET;
    logic [CFG_W-1:0]     cfg_data = '0;

    // allocator image
    bit                alloc_bits [0:DEF_MAX_ENTRIES-1];
    int unsigned       used_entries;
    int unsigned       last_grant;
    logic [CFG_W-1:0]  base_reg;
    logic [CNT_W-1:0]  count_reg;
    int unsigned       recent_grants [0:15];
    int unsigned       grant_total;
    alloc_result_t     pending_results [$];

    int unsigned accepted_requests;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned n_done;
    int unsigned n_no_change;
    int unsigned n_none_free;
    int unsigned n_range;
    int unsigned stall_left;
    bit          stall_used;

    script_row_t script_rows [0:27] = '{
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_ALLOC, 32'd0, 1'b1, '{STAT_DONE, 32'd1, 17'd65535}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_ALLOC, 32'd0, 1'b1, '{STAT_DONE, 32'd2, 17'd65534}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_MARK, 32'd0, 1'b1, '{STAT_DONE, 32'd0, 17'd65533}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_MARK, 32'd0, 1'b1,
          '{STAT_NO_CHANGE, 32'd0, 17'd65533}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_RELEASE, 32'd5, 1'b1,
          '{STAT_NO_CHANGE, 32'd0, 17'd65533}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_RELEASE, 32'd2, 1'b1,
          '{STAT_DONE, 32'd0, 17'd65534}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_MARK, 32'd65535, 1'b1,
          '{STAT_DONE, 32'd0, 17'd65533}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_MARK, 32'd65536, 1'b1,
          '{STAT_RANGE, 32'd0, 17'd65533}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_RELEASE, 32'hFFFF_FFFF, 1'b1,
          '{STAT_RANGE, 32'd0, 17'd65533}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_UNUSED, 32'hFFFF_FFFF, 1'b1,
          '{STAT_NO_CHANGE, 32'd0, 17'd65533}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_ALLOC, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b1, REG_BASE_OFFSET, 32'hFFFF_FFFF, CMD_MARK, 32'd0, 1'b0, '0},
        '{1'b1, REG_ENTRY_COUNT, 32'd4, CMD_MARK, 32'd0, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_ALLOC, 32'd0, 1'b1, '{STAT_NONE_FREE, 32'd0, 17'd0}},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_RELEASE, 32'd0, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_MARK, 32'd3, 1'b1, '{STAT_RANGE, 32'd0, 17'd0}},
        '{1'b1, REG_BASE_OFFSET, 32'd0, CMD_MARK, 32'd0, 1'b0, '0},
        '{1'b1, REG_ENTRY_COUNT, 32'h0001_FFFF, CMD_MARK, 32'd0, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_RELEASE, 32'd0, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_RELEASE, 32'd1, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_RELEASE, 32'd3, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_RELEASE, 32'd65535, 1'b0, '0},
        '{1'b1, REG_ENTRY_COUNT, 32'd0, CMD_MARK, 32'd0, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_ALLOC, 32'd0, 1'b1, '{STAT_NONE_FREE, 32'd0, 17'd0}},
        '{1'b1, REG_ENTRY_COUNT, 32'hFFFE_0040, CMD_MARK, 32'd0, 1'b0, '0},
        '{1'b0, REG_BASE_OFFSET, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0}
    };

    next_fit_bitmap_allocator_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .position        (position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .result_position (result_position),
        .free_count      (free_count),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned live_limit();
        if (count_reg == '0)
            return 1;
        if (count_reg > DEF_MAX_ENTRIES)
            return DEF_MAX_ENTRIES;
        return 32'(count_reg);
    endfunction

    function automatic alloc_result_t predict_request(input logic [CMD_W-1:0] cmd,
                                                      input logic [POS_W-1:0] pos);
        int unsigned   n;
        int unsigned   idx;
        logic [31:0]   rel;
        bit            found;
        alloc_result_t r;
        n = live_limit();
        r = '0;
        r.status = STAT_NO_CHANGE;
        if (cmd == CMD_MARK || cmd == CMD_RELEASE)
        begin
            rel = pos - base_reg;
            if (rel >= n)
                r.status = STAT_RANGE;
            else if (cmd == CMD_MARK)
            begin
                if (!alloc_bits[rel])
                begin
                    alloc_bits[rel] = 1'b1;
                    if (used_entries < DEF_MAX_ENTRIES)
                        used_entries++;
                    r.status = STAT_DONE;
                end
            end
            else if (alloc_bits[rel])
            begin
                alloc_bits[rel] = 1'b0;
                if (used_entries > 0)
                    used_entries--;
                r.status = STAT_DONE;
            end
        end
        else if (cmd == CMD_ALLOC)
        begin
            if (used_entries >= n)
                r.status = STAT_NONE_FREE;
            else
            begin
                // next fit: resume after the last grant, wrap to 1 (or 0 when n is 1)
                idx = (last_grant < n - 1) ? last_grant + 1 : 1;
                if (idx >= n)
                    idx = 0;
                found = 1'b0;
                for (int unsigned k = 0; k < n && !found; k++)
                begin
                    if (!alloc_bits[idx])
                        found = 1'b1;
                    else
                    begin
                        idx++;
                        if (idx >= n)
                            idx = 0;
                    end
                end
                if (found)
                begin
                    alloc_bits[idx] = 1'b1;
                    if (used_entries < DEF_MAX_ENTRIES)
                        used_entries++;
                    last_grant = idx;
                    recent_grants[grant_total % 16] = idx;
                    grant_total++;
                    r.result_position = idx + base_reg;
                    r.status = STAT_DONE;
                end
                else
                    r.status = STAT_NONE_FREE;
            end
        end
        r.free_count = CNT_W'((used_entries < n) ? n - used_entries : 0);
        return r;
    endfunction

    task automatic flag_error(input string what, input alloc_result_t want,
                              input alloc_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR %0t: %s: expected status %0d pos %h free %0d, got status %0d pos %h free %0d",
                     $time, what, want.status, want.result_position, want.free_count,
                     got.status, got.result_position, got.free_count);
    endtask

    task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input bit typed, input alloc_result_t typed_res);
        int            gap;
        alloc_result_t predicted;
        gap = 0;
        if (accepted_requests < CALM_LO || accepted_requests >= CALM_HI)
            while ($urandom_range(99) < 21)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        position <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accepted_requests++;
        predicted = predict_request(cmd, pos);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (sel == REG_BASE_OFFSET)
            base_reg = value;
        else
            count_reg = value[CNT_W-1:0];
    endtask

    // result side: check, tally, random stalls, one long hold-off
    always @(posedge clk)
    begin
        alloc_result_t seen;
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.status          = status;
            seen.result_position = result_position;
            seen.free_count      = free_count;
            results_seen++;
            case (status)
                STAT_DONE:      n_done++;
                STAT_NO_CHANGE: n_no_change++;
                STAT_NONE_FREE: n_none_free++;
                default:        n_range++;
            endcase
            if (pending_results.size() == 0)
                flag_error("result with no request pending", '0, seen);
            else
            begin
                want = pending_results.pop_front();
                if (want.status !== seen.status || want.result_position !== seen.result_position
                    || want.free_count !== seen.free_count)
                    flag_error("result mismatch", want, seen);
            end
        end
        if (!stall_used && results_seen == 250)
        begin
            stall_left = 400;
            stall_used = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (results_seen >= CALM_LO && results_seen < CALM_HI)
                         || $urandom_range(99) >= 21;
    end

    initial
    begin
        #60000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int unsigned      n_live;
        int unsigned      idx;
        int               roll;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [CFG_W-1:0] phase_base [0:N_PHASES-1];
        logic [CFG_W-1:0] phase_count [0:N_PHASES-1];
        int               phase_items [0:N_PHASES-1];

        foreach (alloc_bits[i])
            alloc_bits[i] = 1'b0;
        foreach (recent_grants[i])
            recent_grants[i] = 0;
        used_entries = 0;
        last_grant = 0;
        base_reg = '0;
        count_reg = 17'd65536;
        grant_total = 0;
        accepted_requests = 0;
        results_seen = 0;
        mismatches = 0;
        n_done = 0;
        n_no_change = 0;
        n_none_free = 0;
        n_range = 0;
        stall_left = 0;
        stall_used = 1'b0;

        // entry counts rise from phase to phase so that earlier grants never lock out a phase
        phase_base  = '{32'hFFFF_FFFF, $urandom, 32'h8000_0000, 32'd0, 32'hFFFF_FFC0,
                        $urandom, $urandom};
        phase_count = '{32'd1, 32'd64, 32'd65, 32'd130, 32'd200, 32'd1000, 32'd65536};
        phase_items = '{40, 152, 152, 152, 152, 152, 152};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script_rows[i])
        begin
            if (script_rows[i].is_reg)
            begin
                drain_results();
                write_reg(script_rows[i].reg_sel, script_rows[i].reg_value);
            end
            else
                offer_request(script_rows[i].cmd, script_rows[i].pos, script_rows[i].typed,
                              script_rows[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            write_reg(REG_BASE_OFFSET, phase_base[p]);
            write_reg(REG_ENTRY_COUNT, phase_count[p]);
            n_live = live_limit();
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (p == 4 && i == 60)
                    drain_results();
                roll = $urandom_range(99);
                if (roll < 45)
                begin
                    cmd = CMD_ALLOC;
                    pos = $urandom;
                end
                else if (roll < 70)
                begin
                    cmd = CMD_RELEASE;
                    idx = ($urandom_range(1) == 1) ? recent_grants[$urandom_range(15)]
                                                   : $urandom_range(n_live - 1);
                    pos = idx + base_reg;
                end
                else if (roll < 90)
                begin
                    cmd = CMD_MARK;
                    idx = $urandom_range(n_live - 1);
                    pos = idx + base_reg;
                end
                else
                begin
                    cmd = CMD_W'($urandom_range(3));
                    pos = $urandom;
                end
                offer_request(cmd, pos, 1'b0, '0);
            end
        end

        drain_results();
        repeat (1100) @(posedge clk);
        $display("Run: %0d requests over %0d entry-count settings, %0d grants issued",
                 accepted_requests, N_PHASES + 5, grant_total);
        $display("Results: %0d done, %0d no change, %0d none free, %0d out of range, %0d mismatches",
                 n_done, n_no_change, n_none_free, n_range, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
